// ===== rtl/rmcb_pkg.sv =====
// ----------------------------------------------------------------------------
// rmcb_pkg
// Types and constants shared by the mean-based contrast/brightness block.
// ----------------------------------------------------------------------------
package rmcb_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int CONTRAST_W = 10;
  localparam int BRIGHT_W   = 2;
  localparam int SUM_W      = 32;
  localparam int PROD_W     = PIX_W + CONTRAST_W;
  localparam int BASE_W     = PIX_W + BRIGHT_W;
  localparam int DIV_W      = SUM_W + PIX_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CONTRAST_W-1:0] CONTRAST_RESET = 10'd691;
  localparam logic [BRIGHT_W-1:0]   BRIGHT_RESET   = 2'd2;
  localparam logic [PIX_W-1:0]      PIX_MAX        = 8'hFF;
  localparam logic [1:0]            CH_LAST        = 2'd2;
  localparam logic [1:0]            QUEUE_DEPTH    = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CONTRAST = 1'b0;
  localparam logic REG_BRIGHT   = 1'b1;

  typedef enum logic [1:0] {
    ITEM_ACCUM,
    ITEM_ACCUM_LAST,
    ITEM_ADJUST
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/rmcb_front.sv =====
// ----------------------------------------------------------------------------
// rmcb_front
// Input side: classifies each pixel request and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module rmcb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       func,
  input  logic [rmcb_pkg::PIX_W-1:0] in_red,
  input  logic [rmcb_pkg::PIX_W-1:0] in_green,
  input  logic [rmcb_pkg::PIX_W-1:0] in_blue,
  input  logic                       in_last,
  output logic                       full,
  output rmcb_pkg::item_t            item,
  output logic                       item_valid,
  input  logic                       item_take
);

  rmcb_pkg::item_t entry [2];
  rmcb_pkg::item_t wr_item;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            wr_en;

  assign full       = (fill == rmcb_pkg::QUEUE_DEPTH);
  assign item_valid = (fill != 2'd0);
  assign item       = entry[rd_ptr];
  assign wr_en      = push && !full;

  always_comb begin
    wr_item.red   = in_red;
    wr_item.green = in_green;
    wr_item.blue  = in_blue;
    wr_item.last  = in_last;
    if (func) begin
      wr_item.kind = rmcb_pkg::ITEM_ADJUST;
    end else if (in_last) begin
      wr_item.kind = rmcb_pkg::ITEM_ACCUM_LAST;
    end else begin
      wr_item.kind = rmcb_pkg::ITEM_ACCUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        entry[wr_ptr] <= wr_item;
        wr_ptr        <= !wr_ptr;
      end
      if (item_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, item_take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/rmcb_div.sv =====
// ----------------------------------------------------------------------------
// rmcb_div
// Saturating restoring divider: quotient min(dividend/divisor, 255), 0 for a
// zero divisor. One quotient bit per cycle, 8 steps after the range check.
// ----------------------------------------------------------------------------
module rmcb_div (
  input  logic               clk,
  input  logic               rst,
  input  rmcb_pkg::div_req_t req,
  output rmcb_pkg::div_rsp_t rsp
);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_t;

  div_state_t                      state;
  logic [rmcb_pkg::DIV_W-1:0]      rem;
  logic [rmcb_pkg::DIV_W-1:0]      dsh;
  logic [rmcb_pkg::PIX_W-1:0]      q;
  logic [2:0]                      step;
  logic                            done;
  logic [rmcb_pkg::DIV_W-1:0]      rem_init;
  logic [rmcb_pkg::DIV_W-1:0]      limit;

  assign rem_init     = rmcb_pkg::DIV_W'(req.dividend);
  assign limit        = {req.divisor, 8'b0};
  assign rsp.done     = done;
  assign rsp.quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      q     <= '0;
      step  <= 3'd0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            if (req.divisor == '0) begin
              q    <= '0;
              done <= 1'b1;
            end else if (rem_init >= limit) begin
              q    <= rmcb_pkg::PIX_MAX;
              done <= 1'b1;
            end else begin
              rem   <= rem_init;
              dsh   <= {1'b0, req.divisor, 7'b0};
              q     <= '0;
              step  <= 3'd7;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[rmcb_pkg::PIX_W-2:0], 1'b1};
          end else begin
            q   <= {q[rmcb_pkg::PIX_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (step == 3'd0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            step <= step - 3'd1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rmcb_back.sv =====
// ----------------------------------------------------------------------------
// rmcb_back
// Execution side: channel sums and pixel count, mean formation through the
// shared divider, and a two-stage adjust pipeline ending in the result register.
// ----------------------------------------------------------------------------
module rmcb_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rmcb_pkg::item_t                 item,
  input  logic                            item_valid,
  output logic                            item_take,
  input  logic [rmcb_pkg::CONTRAST_W-1:0] contrast_gain,
  input  logic [rmcb_pkg::BRIGHT_W-1:0]   brightness_gain,
  output rmcb_pkg::div_req_t              div_req,
  input  rmcb_pkg::div_rsp_t              div_rsp,
  output logic [rmcb_pkg::PIX_W-1:0]      out_red,
  output logic [rmcb_pkg::PIX_W-1:0]      out_green,
  output logic [rmcb_pkg::PIX_W-1:0]      out_blue,
  output logic                            out_last,
  output logic                            empty,
  input  logic                            pop
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV_LOAD,
    B_DIV_WAIT
  } back_state_t;

  back_state_t                       state;
  logic [1:0]                        ch;
  logic [rmcb_pkg::SUM_W-1:0]        sum  [rmcb_pkg::NUM_CH];
  logic [COUNT_BITS-1:0]             count;
  logic [rmcb_pkg::PIX_W-1:0]        mean [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::PIX_W-1:0]        pix  [rmcb_pkg::NUM_CH];

  logic                              s1_valid;
  logic                              s1_last;
  logic                              s1_neg  [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::PROD_W-1:0]       s1_prod [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::BASE_W-1:0]       s1_base [rmcb_pkg::NUM_CH];

  logic                              out_valid;
  logic [rmcb_pkg::PIX_W-1:0]        out_pix [rmcb_pkg::NUM_CH];

  logic                              neg     [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::PIX_W-1:0]        diff    [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::PROD_W-1:0]       prod    [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::BASE_W-1:0]       base    [rmcb_pkg::NUM_CH];
  logic signed [rmcb_pkg::BASE_W+1:0] total  [rmcb_pkg::NUM_CH];
  logic [rmcb_pkg::PIX_W-1:0]        clamped [rmcb_pkg::NUM_CH];

  logic adv2;
  logic s1_free;
  logic take_adjust;
  logic take_accum;

  assign pix[0] = item.red;
  assign pix[1] = item.green;
  assign pix[2] = item.blue;

  assign adv2        = s1_valid && (!out_valid || pop);
  assign s1_free     = !s1_valid || adv2;
  assign item_take   = (state == B_IDLE) && item_valid &&
                       ((item.kind != rmcb_pkg::ITEM_ADJUST) || s1_free);
  assign take_adjust = item_take && (item.kind == rmcb_pkg::ITEM_ADJUST);
  assign take_accum  = item_take && (item.kind != rmcb_pkg::ITEM_ADJUST);

  assign div_req.start    = (state == B_DIV_LOAD);
  assign div_req.dividend = sum[ch];
  assign div_req.divisor  = rmcb_pkg::SUM_W'(count);

  assign empty     = !out_valid;
  assign out_red   = out_pix[0];
  assign out_green = out_pix[1];
  assign out_blue  = out_pix[2];

  always_comb begin
    for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
      neg[c]  = pix[c] < mean[c];
      diff[c] = neg[c] ? (mean[c] - pix[c]) : (pix[c] - mean[c]);
      prod[c] = rmcb_pkg::PROD_W'(diff[c]) * rmcb_pkg::PROD_W'(contrast_gain);
      base[c] = rmcb_pkg::BASE_W'(mean[c]) * rmcb_pkg::BASE_W'(brightness_gain);
    end
  end

  // magnitude truncates toward zero, sign restored, then clamp to 0..255
  always_comb begin
    for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
      if (s1_neg[c]) begin
        total[c] = $signed({2'b00, s1_base[c]}) -
                   $signed({2'b00, s1_prod[c][rmcb_pkg::PROD_W-1:8]});
      end else begin
        total[c] = $signed({2'b00, s1_base[c]}) +
                   $signed({2'b00, s1_prod[c][rmcb_pkg::PROD_W-1:8]});
      end
      if (total[c] < 0) begin
        clamped[c] = '0;
      end else if (total[c] > $signed({4'b0000, rmcb_pkg::PIX_MAX})) begin
        clamped[c] = rmcb_pkg::PIX_MAX;
      end else begin
        clamped[c] = total[c][rmcb_pkg::PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      ch        <= 2'd0;
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
        sum[c]  <= '0;
        mean[c] <= '0;
      end
    end else begin
      case (state)
        B_IDLE: begin
          if (take_accum) begin
            for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
              sum[c] <= sum[c] + rmcb_pkg::SUM_W'(pix[c]);
            end
            count <= count + COUNT_BITS'(1);
            if (item.kind == rmcb_pkg::ITEM_ACCUM_LAST) begin
              ch    <= 2'd0;
              state <= B_DIV_LOAD;
            end
          end
        end
        B_DIV_LOAD: state <= B_DIV_WAIT;
        B_DIV_WAIT: begin
          if (div_rsp.done) begin
            mean[ch] <= div_rsp.quotient;
            if (ch == rmcb_pkg::CH_LAST) begin
              for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
                sum[c] <= '0;
              end
              count <= '0;
              state <= B_IDLE;
            end else begin
              ch    <= ch + 2'd1;
              state <= B_DIV_LOAD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase

      if (take_adjust) begin
        s1_valid <= 1'b1;
        s1_last  <= item.last;
        for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
          s1_neg[c]  <= neg[c];
          s1_prod[c] <= prod[c];
          s1_base[c] <= base[c];
        end
      end else if (adv2) begin
        s1_valid <= 1'b0;
      end

      if (adv2) begin
        out_valid <= 1'b1;
        out_last  <= s1_last;
        for (int c = 0; c < rmcb_pkg::NUM_CH; c++) begin
          out_pix[c] <= clamped[c];
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rgb_mean_contrast_brightness.sv =====
// ----------------------------------------------------------------------------
// rgb_mean_contrast_brightness - two-pass RGB mean contrast/brightness adjust
// Accumulate and adjust pixels are taken one per cycle while the back end is
// idle and the output does not stall; an adjust result passes through the
// stage-1 and result registers to the output. The last accumulate pixel holds
// the back end while the shared divider forms the three channel means in turn.
// Synchronous reset clears sums, count, means and queues; gains reset to 691, 2.
// ----------------------------------------------------------------------------
module rgb_mean_contrast_brightness #(
  parameter int COUNT_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmcb_pkg::ADDR_W-1:0]      paddr,
  input  logic [rmcb_pkg::DATA_W-1:0]      pwdata,
  output logic [rmcb_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             push,
  output logic                             full,
  input  logic                             func,
  input  logic [rmcb_pkg::PIX_W-1:0]       in_red,
  input  logic [rmcb_pkg::PIX_W-1:0]       in_green,
  input  logic [rmcb_pkg::PIX_W-1:0]       in_blue,
  input  logic                             in_last,
  output logic                             empty,
  input  logic                             pop,
  output logic [rmcb_pkg::PIX_W-1:0]       out_red,
  output logic [rmcb_pkg::PIX_W-1:0]       out_green,
  output logic [rmcb_pkg::PIX_W-1:0]       out_blue,
  output logic                             out_last
);

  logic [rmcb_pkg::CONTRAST_W-1:0] contrast_gain;
  logic [rmcb_pkg::BRIGHT_W-1:0]   brightness_gain;
  rmcb_pkg::item_t                 item;
  logic                            item_valid;
  logic                            item_take;
  rmcb_pkg::div_req_t              div_req;
  rmcb_pkg::div_rsp_t              div_rsp;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == rmcb_pkg::REG_BRIGHT) begin
      prdata = rmcb_pkg::DATA_W'(brightness_gain);
    end else begin
      prdata = rmcb_pkg::DATA_W'(contrast_gain);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_gain   <= rmcb_pkg::CONTRAST_RESET;
      brightness_gain <= rmcb_pkg::BRIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == rmcb_pkg::REG_CONTRAST) begin
        contrast_gain <= pwdata[rmcb_pkg::CONTRAST_W-1:0];
      end else begin
        brightness_gain <= pwdata[rmcb_pkg::BRIGHT_W-1:0];
      end
    end
  end

  rmcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .func       (func),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .in_last    (in_last),
    .full       (full),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  rmcb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rmcb_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .item            (item),
    .item_valid      (item_valid),
    .item_take       (item_take),
    .contrast_gain   (contrast_gain),
    .brightness_gain (brightness_gain),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last        (out_last),
    .empty           (empty),
    .pop             (pop)
  );

`ifndef SYNTHESIS
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_take |-> item_valid)
    else $error("back took a request from an empty queue");

  a_no_take_on_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> !item_take)
    else $error("request taken while means are being formed");

  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.done)
    else $error("divider start overlaps a finishing division");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule
